// ===== hw/rtl/psrc_pkg.sv =====
// Shared constants and register codes for the self-region point classifier.
package psrc_pkg;

  localparam int unsigned MaxCapsulesDef = 16;
  localparam int unsigned CoordBitsDef   = 16;
  localparam int unsigned SlotW          = 4;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned OutDataW       = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFpEnable = 2'd0,
    CfgFpZLow   = 2'd1,
    CfgFpZHigh  = 2'd2,
    CfgFpRadius = 2'd3
  } cfg_reg_e;

  function automatic int unsigned in_data_w(int unsigned coord_bits);
    return ((SlotW + 7 * coord_bits - 1 + 7) / 8) * 8;
  endfunction

endpackage

// ===== hw/rtl/point_self_region_classifier_unit.sv =====
// One beat per cycle sustained while the output is not stalled.
// Six register stages: differences, products, sums and cross terms, split squares,
// wide sums, compare and lane reduction into the output register.
// Every capsule slot has its own lane, so the slot count does not change the rate.
// A stalled output holds the whole pipeline. Reset (rst_ni low, asynchronous)
// empties the pipeline, clears footprint registers and disables all capsule slots.
module point_self_region_classifier_unit #(
  parameter int unsigned MAX_CAPSULES = psrc_pkg::MaxCapsulesDef,
  parameter int unsigned COORD_BITS   = psrc_pkg::CoordBitsDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_tvalid_i,
  output logic                                          s_tready_o,
  // capsule_slot, pos_x, pos_y, pos_z, end_x, end_y, end_z, capsule_radius_in
  input  logic [psrc_pkg::in_data_w(COORD_BITS)-1:0]    s_tdata_i,
  // func
  input  logic                                          s_tuser_i,
  output logic                                          m_tvalid_o,
  input  logic                                          m_tready_i,
  // is_self
  output logic [psrc_pkg::OutDataW-1:0]                 m_tdata_o,
  // was_write
  output logic                                          m_tuser_o,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [psrc_pkg::CfgIdxW-1:0]                  cfg_index_i,
  input  logic [COORD_BITS-1:0]                         cfg_data_i
);
  import psrc_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned RB = W - 1;
  localparam int unsigned A  = W + 1;
  localparam int unsigned P  = 2 * A;
  localparam int unsigned D  = P + 2;
  localparam int unsigned H  = W + 1;
  localparam int unsigned C  = 2 * H;
  localparam int unsigned R2 = 2 * RB;
  localparam int unsigned LH = 4 * W + 4;
  localparam int unsigned N  = MAX_CAPSULES;

  // input fields
  logic [SlotW-1:0]      slot;
  logic signed [W-1:0]   pin [3];
  logic signed [W-1:0]   ein [3];
  logic [RB-1:0]         rin;

  assign slot   = s_tdata_i[SlotW-1:0];
  assign pin[0] = s_tdata_i[SlotW+W-1:SlotW];
  assign pin[1] = s_tdata_i[SlotW+2*W-1:SlotW+W];
  assign pin[2] = s_tdata_i[SlotW+3*W-1:SlotW+2*W];
  assign ein[0] = s_tdata_i[SlotW+4*W-1:SlotW+3*W];
  assign ein[1] = s_tdata_i[SlotW+5*W-1:SlotW+4*W];
  assign ein[2] = s_tdata_i[SlotW+6*W-1:SlotW+5*W];
  assign rin    = s_tdata_i[SlotW+7*W-2:SlotW+6*W];

  logic adv, s_acc;
  logic m_tvalid_q, self_q, wrout_q;

  assign adv         = !m_tvalid_q || m_tready_i;
  assign s_tready_o  = adv;
  assign s_acc       = s_tvalid_i && adv;
  assign cfg_ready_o = 1'b1;

  // configuration and capsule table
  logic                fp_en_q;
  logic signed [W-1:0] fp_zlo_q, fp_zhi_q;
  logic [RB-1:0]       fp_r_q;
  logic signed [W-1:0] cs_q [N][3];
  logic signed [W-1:0] ce_q [N][3];
  logic [RB-1:0]       cr_q [N];

  // pipeline valid and kind bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic wr1_q, wr2_q, wr3_q, wr4_q, wr5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_en_q    <= 1'b0;
      fp_zlo_q   <= '0;
      fp_zhi_q   <= '0;
      fp_r_q     <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      v5_q       <= 1'b0;
      m_tvalid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        cr_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgFpEnable: fp_en_q  <= cfg_data_i[0];
          CfgFpZLow:   fp_zlo_q <= cfg_data_i;
          CfgFpZHigh:  fp_zhi_q <= cfg_data_i;
          CfgFpRadius: fp_r_q   <= cfg_data_i[RB-1:0];
          default: ;
        endcase
      end
      if (s_acc && s_tuser_i) begin
        for (int i = 0; i < N; i++) begin
          if (int'(slot) == i) cr_q[i] <= rin;
        end
      end
      if (adv) begin
        v1_q       <= s_tvalid_i;
        v2_q       <= v1_q;
        v3_q       <= v2_q;
        v4_q       <= v3_q;
        v5_q       <= v4_q;
        m_tvalid_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && s_tuser_i) begin
      for (int i = 0; i < N; i++) begin
        if (int'(slot) == i) begin
          for (int k = 0; k < 3; k++) begin
            cs_q[i][k] <= pin[k];
            ce_q[i][k] <= ein[k];
          end
        end
      end
    end
  end

  // stage 1: differences
  logic signed [A-1:0] ap1_q [N][3];
  logic signed [A-1:0] bp1_q [N][3];
  logic signed [A-1:0] ab1_q [N][3];
  logic [RB-1:0]       r1_q [N];
  logic                en1_q [N];
  logic signed [W-1:0] fx1_q, fy1_q;
  logic                fz1_q;
  // stage 2: products
  logic signed [P-1:0] pr2_q [N][3][3];
  logic [P-1:0]        aa2_q [N][3];
  logic [P-1:0]        bb2_q [N][3];
  logic [P-1:0]        ll2_q [N][3];
  logic [R2-1:0]       r2_2_q [N];
  logic                en2_q [N];
  logic [2*W-1:0]      xx2_q, yy2_q;
  logic [R2-1:0]       rf2_q;
  logic                fz2_q;
  // stage 3: sums and cross terms
  logic signed [D-1:0] dot3_q [N];
  logic [P-1:0]        lap3_q [N];
  logic [P-1:0]        lbp3_q [N];
  logic [P-1:0]        len3_q [N];
  logic [C-1:0]        cm3_q [N][3];
  logic [R2-1:0]       r2_3_q [N];
  logic                en3_q [N];
  logic                fp3_q;
  // stage 4: flags and split squares
  logic                le0_4_q [N], geL_4_q [N], ha4_q [N], hb4_q [N], en4_q [N];
  logic [2*H-1:0]      hh4_q [N][3];
  logic [2*H-1:0]      hl4_q [N][3];
  logic [2*H-1:0]      lo4_q [N][3];
  logic [R2+H-1:0]     rlh4_q [N];
  logic [R2+H-1:0]     rll4_q [N];
  logic                fp4_q;
  // stage 5: wide sums
  logic                le0_5_q [N], geL_5_q [N], ha5_q [N], hb5_q [N], en5_q [N];
  logic [LH-1:0]       lhs5_q [N];
  logic [LH-1:0]       rhs5_q [N];
  logic                fp5_q;

  logic signed [P:0]   crs [N][3];
  logic [C-1:0]        crm [N][3];
  logic [N-1:0]        hit;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      crs[i][0] = (P+1)'(pr2_q[i][1][2]) - (P+1)'(pr2_q[i][2][1]);
      crs[i][1] = (P+1)'(pr2_q[i][2][0]) - (P+1)'(pr2_q[i][0][2]);
      crs[i][2] = (P+1)'(pr2_q[i][0][1]) - (P+1)'(pr2_q[i][1][0]);
      for (int k = 0; k < 3; k++) begin
        crm[i][k] = crs[i][k][P] ? C'(-crs[i][k]) : C'(crs[i][k]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit[i] = en5_q[i] && (le0_5_q[i] ? ha5_q[i] :
                            geL_5_q[i] ? hb5_q[i] : (lhs5_q[i] <= rhs5_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      wr1_q <= s_tuser_i;
      fx1_q <= pin[0];
      fy1_q <= pin[1];
      fz1_q <= fp_en_q && (pin[2] >= fp_zlo_q) && (pin[2] <= fp_zhi_q);
      for (int i = 0; i < N; i++) begin
        for (int k = 0; k < 3; k++) begin
          ap1_q[i][k] <= A'(pin[k]) - A'(cs_q[i][k]);
          bp1_q[i][k] <= A'(pin[k]) - A'(ce_q[i][k]);
          ab1_q[i][k] <= A'(ce_q[i][k]) - A'(cs_q[i][k]);
        end
        r1_q[i]  <= cr_q[i];
        en1_q[i] <= (cr_q[i] != '0);
      end
      // stage 2
      wr2_q <= wr1_q;
      xx2_q <= $unsigned((2*W)'(fx1_q) * (2*W)'(fx1_q));
      yy2_q <= $unsigned((2*W)'(fy1_q) * (2*W)'(fy1_q));
      rf2_q <= R2'(fp_r_q) * R2'(fp_r_q);
      fz2_q <= fz1_q;
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pr2_q[i][j][k] <= P'(ap1_q[i][j]) * P'(ab1_q[i][k]);
          end
          aa2_q[i][j] <= $unsigned(P'(ap1_q[i][j]) * P'(ap1_q[i][j]));
          bb2_q[i][j] <= $unsigned(P'(bp1_q[i][j]) * P'(bp1_q[i][j]));
          ll2_q[i][j] <= $unsigned(P'(ab1_q[i][j]) * P'(ab1_q[i][j]));
        end
        r2_2_q[i] <= R2'(r1_q[i]) * R2'(r1_q[i]);
        en2_q[i]  <= en1_q[i];
      end
      // stage 3
      wr3_q <= wr2_q;
      fp3_q <= fz2_q && (((2*W+1)'(xx2_q) + (2*W+1)'(yy2_q)) <= (2*W+1)'(rf2_q));
      for (int i = 0; i < N; i++) begin
        dot3_q[i] <= D'(pr2_q[i][0][0]) + D'(pr2_q[i][1][1]) + D'(pr2_q[i][2][2]);
        lap3_q[i] <= aa2_q[i][0] + aa2_q[i][1] + aa2_q[i][2];
        lbp3_q[i] <= bb2_q[i][0] + bb2_q[i][1] + bb2_q[i][2];
        len3_q[i] <= ll2_q[i][0] + ll2_q[i][1] + ll2_q[i][2];
        for (int k = 0; k < 3; k++) begin
          cm3_q[i][k] <= crm[i][k];
        end
        r2_3_q[i] <= r2_2_q[i];
        en3_q[i]  <= en2_q[i];
      end
      // stage 4
      wr4_q <= wr3_q;
      fp4_q <= fp3_q;
      for (int i = 0; i < N; i++) begin
        le0_4_q[i] <= dot3_q[i][D-1] || (dot3_q[i] == '0);
        geL_4_q[i] <= ((D-1)'(dot3_q[i][D-2:0]) >= (D-1)'(len3_q[i]));
        ha4_q[i]   <= (lap3_q[i] <= P'(r2_3_q[i]));
        hb4_q[i]   <= (lbp3_q[i] <= P'(r2_3_q[i]));
        en4_q[i]   <= en3_q[i];
        for (int k = 0; k < 3; k++) begin
          hh4_q[i][k] <= (2*H)'(cm3_q[i][k][C-1:H]) * (2*H)'(cm3_q[i][k][C-1:H]);
          hl4_q[i][k] <= (2*H)'(cm3_q[i][k][C-1:H]) * (2*H)'(cm3_q[i][k][H-1:0]);
          lo4_q[i][k] <= (2*H)'(cm3_q[i][k][H-1:0]) * (2*H)'(cm3_q[i][k][H-1:0]);
        end
        rlh4_q[i] <= (R2+H)'(r2_3_q[i]) * (R2+H)'(len3_q[i][P-1:H]);
        rll4_q[i] <= (R2+H)'(r2_3_q[i]) * (R2+H)'(len3_q[i][H-1:0]);
      end
      // stage 5
      wr5_q <= wr4_q;
      fp5_q <= fp4_q;
      for (int i = 0; i < N; i++) begin
        le0_5_q[i] <= le0_4_q[i];
        geL_5_q[i] <= geL_4_q[i];
        ha5_q[i]   <= ha4_q[i];
        hb5_q[i]   <= hb4_q[i];
        en5_q[i]   <= en4_q[i];
        lhs5_q[i]  <= (LH'(hh4_q[i][0]) << (2*H)) + (LH'(hl4_q[i][0]) << (H+1))
                    + LH'(lo4_q[i][0])
                    + (LH'(hh4_q[i][1]) << (2*H)) + (LH'(hl4_q[i][1]) << (H+1))
                    + LH'(lo4_q[i][1])
                    + (LH'(hh4_q[i][2]) << (2*H)) + (LH'(hl4_q[i][2]) << (H+1))
                    + LH'(lo4_q[i][2]);
        rhs5_q[i]  <= (LH'(rlh4_q[i]) << H) + LH'(rll4_q[i]);
      end
      // output register
      wrout_q <= wr5_q;
      self_q  <= !wr5_q && (fp5_q || (|hit));
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = OutDataW'(self_q);
  assign m_tuser_o  = wrout_q;

endmodule

// ===== hw/rtl/psrc_checker.sv =====
// Port-level checks for the self-region point classifier, bound to the top level.
module psrc_checker #(
  parameter int unsigned COORD_BITS = psrc_pkg::CoordBitsDef
) (
  input logic                                       clk_i,
  input logic                                       rst_ni,
  input logic                                       s_tvalid_i,
  input logic                                       s_tready_o,
  input logic                                       m_tvalid_o,
  input logic                                       m_tready_i,
  input logic [psrc_pkg::OutDataW-1:0]              m_tdata_o,
  input logic                                       m_tuser_o,
  input logic                                       cfg_ready_o
);
  import psrc_pkg::*;

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o == (!m_tvalid_o || m_tready_i))
    else $error("input ready does not follow output stall");

  a_write_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tdata_o == '0)
    else $error("write acknowledge flagged as self point");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("stalled result beat changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config channel not ready");

endmodule

bind point_self_region_classifier_unit psrc_checker #(.COORD_BITS(COORD_BITS)) u_psrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .s_tvalid_i  (s_tvalid_i),
  .s_tready_o  (s_tready_o),
  .m_tvalid_o  (m_tvalid_o),
  .m_tready_i  (m_tready_i),
  .m_tdata_o   (m_tdata_o),
  .m_tuser_o   (m_tuser_o),
  .cfg_ready_o (cfg_ready_o)
);

// ===== tb/tb.sv =====
// Testbench for the self-region point classifier: directed and random beats checked against a predictor.
`timescale 1ns / 100ps
module tb;
  import psrc_pkg::*;

  localparam int DataW      = in_data_w(CoordBitsDef);
  localparam int StallLimit = 5000;
  localparam int DrainWait  = 12;

  typedef struct {
    bit                 func;
    bit [3:0]           slot;
    logic signed [15:0] px, py, pz, ex, ey, ez;
    bit [14:0]          rad;
  } point_beat_t;

  typedef struct {
    bit is_self;
    bit was_write;
  } verdict_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid_i = 1'b0;
  logic             s_tready_o;
  logic [DataW-1:0] s_tdata_i = '0;
  logic             s_tuser_i = 1'b0;
  logic             m_tvalid_o;
  logic             m_tready_i = 1'b0;
  logic [7:0]       m_tdata_o;
  logic             m_tuser_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [15:0]      cfg_data_i = '0;

  point_self_region_classifier_unit u_dut (.*);

  // predictor state
  bit                 fp_enable;
  logic signed [15:0] fp_z_low, fp_z_high;
  bit [14:0]          fp_radius;
  logic signed [15:0] cap_start [16][3];
  logic signed [15:0] cap_end [16][3];
  bit [14:0]          cap_radius [16];

  verdict_t expected_verdicts[$];
  int       errors;
  int       stall_cycles;
  int       send_idle_pct;
  int       recv_idle_pct;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) m_tready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("%0t watchdog: no beat accepted", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t unexpected result: is_self %0d was_write %0d", $time,
                 m_tdata_o[0], m_tuser_o);
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (m_tdata_o[0] !== exp_v.is_self) begin
          errors++;
          $display("%0t is_self mismatch: expected %0d actual %0d", $time,
                   exp_v.is_self, m_tdata_o[0]);
        end
        if (m_tuser_o !== exp_v.was_write) begin
          errors++;
          $display("%0t was_write mismatch: expected %0d actual %0d", $time,
                   exp_v.was_write, m_tuser_o);
        end
      end
    end
  end

  function automatic logic [127:0] sq_wide(longint v);
    logic signed [127:0] w;
    w = v;
    return w * w;
  endfunction

  function automatic bit hits_capsule(int s, longint p[3]);
    longint ab[3], ap[3], bp[3], cr[3];
    longint dot, seg_len, ap_len, bp_len, r2;
    logic [127:0] lhs, rhs;
    for (int i = 0; i < 3; i++) begin
      ab[i] = longint'(cap_end[s][i]) - longint'(cap_start[s][i]);
      ap[i] = p[i] - longint'(cap_start[s][i]);
      bp[i] = p[i] - longint'(cap_end[s][i]);
    end
    r2 = longint'(cap_radius[s]) * longint'(cap_radius[s]);
    seg_len = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
    ap_len = ap[0] * ap[0] + ap[1] * ap[1] + ap[2] * ap[2];
    bp_len = bp[0] * bp[0] + bp[1] * bp[1] + bp[2] * bp[2];
    dot = ap[0] * ab[0] + ap[1] * ab[1] + ap[2] * ab[2];
    if (dot <= 0) return ap_len <= r2;
    if (dot >= seg_len) return bp_len <= r2;
    cr[0] = ap[1] * ab[2] - ap[2] * ab[1];
    cr[1] = ap[2] * ab[0] - ap[0] * ab[2];
    cr[2] = ap[0] * ab[1] - ap[1] * ab[0];
    lhs = sq_wide(cr[0]) + sq_wide(cr[1]) + sq_wide(cr[2]);
    rhs = 128'(r2) * 128'(seg_len);
    return lhs <= rhs;
  endfunction

  function automatic verdict_t classify(point_beat_t b);
    verdict_t v;
    longint p[3];
    longint rr;
    v.is_self = 1'b0;
    v.was_write = b.func;
    if (b.func) begin
      cap_start[b.slot] = '{b.px, b.py, b.pz};
      cap_end[b.slot] = '{b.ex, b.ey, b.ez};
      cap_radius[b.slot] = b.rad;
      return v;
    end
    p = '{longint'(b.px), longint'(b.py), longint'(b.pz)};
    if (fp_enable && b.pz >= fp_z_low && b.pz <= fp_z_high) begin
      rr = p[0] * p[0] + p[1] * p[1];
      if (rr <= longint'(fp_radius) * longint'(fp_radius)) v.is_self = 1'b1;
    end
    for (int s = 0; s < 16; s++)
      if (!v.is_self && cap_radius[s] != 0 && hits_capsule(s, p)) v.is_self = 1'b1;
    return v;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_beat(point_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= b.func;
    s_tdata_i <= {5'b0, b.rad, b.ez, b.ey, b.ex, b.pz, b.py, b.px, b.slot};
    do @(posedge clk_i); while (!s_tready_o);
    expected_verdicts.push_back(classify(b));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // returns at a falling edge with valid still high
  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgFpEnable: fp_enable = value[0];
      CfgFpZLow:   fp_z_low = value;
      CfgFpZHigh:  fp_z_high = value;
      CfgFpRadius: fp_radius = value[14:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_footprint(bit en, int zl, int zh, int rad);
    drain_results();
    write_reg(CfgFpEnable, 16'(en));
    write_reg(CfgFpZLow, 16'(zl));
    write_reg(CfgFpZHigh, 16'(zh));
    write_reg(CfgFpRadius, 16'(rad));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic point_beat_t mk(bit func, int slot, int px, int py, int pz,
                                     int ex = 0, int ey = 0, int ez = 0, int rad = 0);
    point_beat_t b;
    b.func = func; b.slot = 4'(slot); b.rad = 15'(rad);
    b.px = 16'(px); b.py = 16'(py); b.pz = 16'(pz);
    b.ex = 16'(ex); b.ey = 16'(ey); b.ez = 16'(ez);
    return b;
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic int rand_coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic point_beat_t random_beat();
    point_beat_t b;
    int k, t, span;
    b = mk(0, 0, 0, 0, 0);
    b.slot = 4'($urandom_range(15));
    k = $urandom_range(99);
    if (k < 15) begin
      b.func = 1'b1;
      span = ($urandom_range(9) == 0) ? 32768 : 8000;
      b.px = sat16(rand_coord(span)); b.py = sat16(rand_coord(span));
      b.pz = sat16(rand_coord(span));
      if ($urandom_range(5) == 0) begin
        b.ex = b.px; b.ey = b.py; b.ez = b.pz;
      end else begin
        b.ex = sat16(rand_coord(span)); b.ey = sat16(rand_coord(span));
        b.ez = sat16(rand_coord(span));
      end
      case ($urandom_range(9))
        0: b.rad = 0;
        1: b.rad = 15'($urandom_range(32767));
        default: b.rad = 15'($urandom_range(4000, 1));
      endcase
    end else if (k < 75) begin
      // near a stored segment
      b.slot = 4'($urandom_range(15));
      t = $urandom_range(10) - 1;
      span = cap_radius[b.slot] + 64;
      b.px = sat16(cap_start[b.slot][0] + (cap_end[b.slot][0] - cap_start[b.slot][0]) * t / 8
                   + rand_coord(span));
      b.py = sat16(cap_start[b.slot][1] + (cap_end[b.slot][1] - cap_start[b.slot][1]) * t / 8
                   + rand_coord(span));
      b.pz = sat16(cap_start[b.slot][2] + (cap_end[b.slot][2] - cap_start[b.slot][2]) * t / 8
                   + rand_coord(span));
    end else if (k < 88) begin
      span = fp_radius + 200;
      b.px = sat16(rand_coord(span)); b.py = sat16(rand_coord(span));
      b.pz = sat16(rand_coord(4000));
    end else begin
      b.px = 16'($urandom); b.py = 16'($urandom); b.pz = 16'($urandom);
    end
    if (!b.func) begin
      b.ex = 16'($urandom); b.ey = 16'($urandom); b.ez = 16'($urandom);
      b.rad = 15'($urandom);
    end
    return b;
  endfunction

  task automatic test_capsules_directed();
    send_beat(mk(1, 0, 100, 100, 100, 100, 100, 100, 50));
    send_beat(mk(0, 0, 100, 150, 100));
    send_beat(mk(0, 0, 100, 151, 100));
    send_beat(mk(1, 1, 0, 0, 0, 1000, 0, 0, 10));
    send_beat(mk(0, 0, -10, 0, 0));
    send_beat(mk(0, 0, -11, 0, 0));
    send_beat(mk(0, 0, 1010, 0, 0));
    send_beat(mk(0, 0, 1011, 0, 0));
    send_beat(mk(0, 0, 500, 0, 10));
    send_beat(mk(0, 0, 500, 7, 8));
    send_beat(mk(1, 15, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
    send_beat(mk(0, 0, 32767, -32768, 0));
    send_beat(mk(0, 0, -32768, -32768, -32768));
    send_beat(mk(1, 15, 32767, 32767, 32767, -32768, -32768, -32768, 0));
    send_beat(mk(0, 0, 32767, -32768, 0));
    send_beat(mk(0, 15, 1, 1, 1, -1, -1, -1, 32767));
  endtask

  task automatic test_footprint_directed();
    set_footprint(1, -32768, 32767, 32767);
    send_beat(mk(0, 0, 32767, 0, -32768));
    send_beat(mk(0, 0, -32768, 0, 32767));
    send_beat(mk(0, 0, 23170, 23170, 0));
    set_footprint(1, 10, -10, 32767);
    send_beat(mk(0, 0, 0, 0, 0));
    set_footprint(1, -100, 100, 0);
    send_beat(mk(0, 0, 0, 0, 100));
    send_beat(mk(0, 0, 0, 0, 101));
    send_beat(mk(0, 0, 1, 0, -100));
  endtask

  task automatic test_random_phase(int n, int s_idle, int r_idle);
    drain_results();
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      send_beat(random_beat());
    end
  endtask

  initial begin
    errors = 0;
    stall_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fp_enable = 0; fp_z_low = 0; fp_z_high = 0; fp_radius = 0;
    for (int s = 0; s < 16; s++) begin
      cap_radius[s] = 0;
      for (int i = 0; i < 3; i++) begin
        cap_start[s][i] = 0;
        cap_end[s][i] = 0;
      end
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_capsules_directed();
    test_footprint_directed();
    set_footprint(1, -2000, 3000, 1500);
    test_random_phase(530, 29, 55);
    set_footprint(1, -32768, 1000, 32767);
    test_random_phase(530, 55, 29);
    set_footprint(0, 5000, -5000, 700);
    test_random_phase(540, 0, 0);
    drain_results();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
